// ===== rtl/xyz_to_cieluv_unit_defines.svh =====
// Assertion macros shared by the RTL of the XYZ to L*u*v* unit
`ifndef XYZ_TO_CIELUV_UNIT_DEFINES_SVH
`define XYZ_TO_CIELUV_UNIT_DEFINES_SVH

// Condition holds at every edge out of reset
`define XLUV_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("xyz_to_cieluv_unit: invariant violated");

// Same-cycle implication
`define XLUV_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("xyz_to_cieluv_unit: implication violated");

// Next-cycle implication
`define XLUV_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("xyz_to_cieluv_unit: sequence violated");

`endif

// ===== rtl/xyzluv_pkg.sv =====
// Types and constants of the XYZ to L*u*v* unit
package xyzluv_pkg;

    typedef struct packed {
        logic [15:0] x_in;
        logic [15:0] y_in;
        logic [15:0] z_in;
    } xyz_pixel_t;

    typedef struct packed {
        logic [15:0]        lightness;
        logic signed [15:0] u_star;
        logic signed [15:0] v_star;
        logic [1:0]         status;
    } luv_result_t;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_WHITE_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE_Z = 2'd2;

    localparam logic [15:0] WHITE_X_RESET = 16'd15573;
    localparam logic [15:0] WHITE_Y_RESET = 16'd16384;
    localparam logic [15:0] WHITE_Z_RESET = 16'd17839;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SAT       = 2'd1;
    localparam logic [1:0] STATUS_BAD_WHITE = 2'd2;

    // 24389/27 slope scaled to Q8.8, doubled; half the divisor added for round half up
    localparam logic [39:0] LIN_NUM_K = 40'd12487168;
    localparam logic [21:0] LIN_DEN_K = 22'd54;
    localparam logic [39:0] LIN_RND_K = 40'd27;
    localparam logic [31:0] THR_Y_K   = 32'd24389;
    localparam logic [31:0] THR_W_K   = 32'd216;

endpackage

// ===== rtl/xyzluv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
module xyzluv_div
    import xyzluv_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 16,
    parameter int Q_W   = 52,
    parameter int SB_W  = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb_in,
    output logic             out_valid,
    output logic [Q_W-1:0]   quo,
    output logic [SB_W-1:0]  sb_out
);

    logic             vld_reg [1:Q_W];
    logic [DEN_W-1:0] rem_reg [1:Q_W];
    logic [Q_W-1:0]   lo_reg  [1:Q_W];
    logic [Q_W-1:0]   quo_reg [1:Q_W];
    logic [DEN_W-1:0] den_reg [1:Q_W];
    logic [SB_W-1:0]  sb_reg  [1:Q_W];

    genvar i;
    generate
        for (i = 0; i < Q_W; i++) begin : g_stage
            logic             v_i;
            logic [DEN_W-1:0] rem_i;
            logic [Q_W-1:0]   lo_i;
            logic [Q_W-1:0]   quo_i;
            logic [DEN_W-1:0] den_i;
            logic [SB_W-1:0]  sb_i;
            logic [DEN_W:0]   trial;
            logic             take;

            if (i == 0) begin : g_first
                // quotient fits Q_W bits, so the upper numerator part is below den
                assign v_i   = in_valid;
                assign rem_i = DEN_W'(num >> Q_W);
                assign lo_i  = num[Q_W-1:0];
                assign quo_i = '0;
                assign den_i = den;
                assign sb_i  = sb_in;
            end else begin : g_next
                assign v_i   = vld_reg[i];
                assign rem_i = rem_reg[i];
                assign lo_i  = lo_reg[i];
                assign quo_i = quo_reg[i];
                assign den_i = den_reg[i];
                assign sb_i  = sb_reg[i];
            end

            assign trial = {rem_i, lo_i[Q_W-1]};
            assign take  = (trial >= {1'b0, den_i});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i+1] <= 1'b0;
                end
                else
                begin
                    vld_reg[i+1] <= v_i;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i+1] <= take ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
                lo_reg[i+1]  <= lo_i << 1;
                quo_reg[i+1] <= {quo_i[Q_W-2:0], take};
                den_reg[i+1] <= den_i;
                sb_reg[i+1]  <= sb_i;
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W];
    assign quo       = quo_reg[Q_W];
    assign sb_out    = sb_reg[Q_W];

endmodule

// ===== rtl/xyz_to_cieluv_unit.sv =====
// Top level: pipelined CIE XYZ to CIE L*u*v* conversion
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  pixel    | start / busy         | pixel (x_in, y_in, z_in)
//  result   | done strobe          | result (lightness, u_star, v_star, status)
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pixel per clock; busy stays low. From transfer to done the pipeline
// has 1 input stage, 52 stages of Y/Yn division, 18 cube root stages,
// 30 stages of the chroma and linear-lightness dividers and 3 multiply/round
// stages. Reset clears the valid bits and loads the D65 white point.
// The result is a one-cycle strobe; the receiver cannot stall.
`include "xyz_to_cieluv_unit_defines.svh"

module xyz_to_cieluv_unit
    import xyzluv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  xyz_pixel_t             pixel,
    output logic                   done,
    output luv_result_t            result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    localparam int CR_W  = 46;
    localparam int CQ_W  = 54;
    localparam int C_STG = 18;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] wx;
        logic [15:0] wy;
        logic [20:0] d;
        logic [20:0] dn;
        logic [39:0] lin_num;
        logic [21:0] lin_den;
        logic        lin;
        logic        bright;
        logic        bad_white;
    } pre_t;

    typedef struct packed {
        logic [16:0] lcube;
        logic        lin;
        logic        bright;
        logic        bad_white;
        logic        d_zero;
    } grp_t;

    // configuration
    logic [15:0] white_x_reg, white_y_reg, white_z_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_x_reg <= WHITE_X_RESET;
            white_y_reg <= WHITE_Y_RESET;
            white_z_reg <= WHITE_Z_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WHITE_X: white_x_reg <= cfg_data;
                REG_WHITE_Y: white_y_reg <= cfg_data;
                REG_WHITE_Z: white_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    logic s1_valid_reg;
    pre_t s1_reg;
    pre_t s1_next;

    always_comb
    begin
        s1_next.x         = pixel.x_in;
        s1_next.y         = pixel.y_in;
        s1_next.wx        = white_x_reg;
        s1_next.wy        = white_y_reg;
        s1_next.d         = 21'(pixel.x_in) + 21'(pixel.y_in) * 21'd15
                          + 21'(pixel.z_in) * 21'd3;
        s1_next.dn        = 21'(white_x_reg) + 21'(white_y_reg) * 21'd15
                          + 21'(white_z_reg) * 21'd3;
        s1_next.lin_den   = 22'(white_y_reg) * LIN_DEN_K;
        s1_next.lin_num   = 40'(pixel.y_in) * LIN_NUM_K + 40'(white_y_reg) * LIN_RND_K;
        s1_next.lin       = (32'(pixel.y_in) * THR_Y_K) <= (32'(white_y_reg) * THR_W_K);
        s1_next.bright    = 20'(pixel.y_in) >= (20'(white_y_reg) << 4);
        s1_next.bad_white = (white_y_reg == 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // Y * 2^48 / Yn
    logic        q_vld;
    logic [51:0] q_quo;
    pre_t        q_sb;

    xyzluv_div #(
        .NUM_W (64),
        .DEN_W (16),
        .Q_W   (52),
        .SB_W  ($bits(pre_t))
    ) u_div_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .num       ({s1_reg.y, 48'd0}),
        .den       (s1_reg.wy),
        .sb_in     (s1_reg),
        .out_valid (q_vld),
        .quo       (q_quo),
        .sb_out    (q_sb)
    );

    // digit-by-digit cube root, 3 radicand bits per stage
    logic            c_vld_reg [1:C_STG];
    logic [CR_W-1:0] c_r_reg   [1:C_STG];
    logic [17:0]     c_y_reg   [1:C_STG];
    logic [35:0]     c_ysq_reg [1:C_STG];
    logic [CQ_W-1:0] c_q_reg   [1:C_STG];
    pre_t            c_sb_reg  [1:C_STG];

    genvar k;
    generate
        for (k = 0; k < C_STG; k++) begin : g_cbrt
            logic            v_i;
            logic [CR_W-1:0] r_i;
            logic [17:0]     y_i;
            logic [35:0]     ysq_i;
            logic [CQ_W-1:0] q_i;
            pre_t            sb_i;
            logic [CR_W-1:0] rs;
            logic [CR_W-1:0] bnd;
            logic            ge;

            if (k == 0) begin : g_first
                assign v_i   = q_vld;
                assign r_i   = '0;
                assign y_i   = '0;
                assign ysq_i = '0;
                assign q_i   = CQ_W'(q_quo);
                assign sb_i  = q_sb;
            end else begin : g_next
                assign v_i   = c_vld_reg[k];
                assign r_i   = c_r_reg[k];
                assign y_i   = c_y_reg[k];
                assign ysq_i = c_ysq_reg[k];
                assign q_i   = c_q_reg[k];
                assign sb_i  = c_sb_reg[k];
            end

            // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
            assign rs  = {r_i[CR_W-4:0], q_i[CQ_W-1 -: 3]};
            assign bnd = (CR_W'(ysq_i) << 3) + (CR_W'(ysq_i) << 2)
                       + (CR_W'(y_i) << 2) + (CR_W'(y_i) << 1) + CR_W'(1);
            assign ge  = (rs >= bnd);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    c_vld_reg[k+1] <= 1'b0;
                end
                else
                begin
                    c_vld_reg[k+1] <= v_i;
                end
            end

            always_ff @(posedge clk)
            begin
                c_r_reg[k+1]   <= ge ? rs - bnd : rs;
                c_y_reg[k+1]   <= {y_i[16:0], ge};
                c_ysq_reg[k+1] <= ge ? (ysq_i << 2) + (36'(y_i) << 2) + 36'd1
                                     : (ysq_i << 2);
                c_q_reg[k+1]   <= q_i << 3;
                c_sb_reg[k+1]  <= sb_i;
            end
        end
    endgenerate

    pre_t        cb_sb;
    logic [25:0] lc_t;
    grp_t        grp_in;

    assign cb_sb  = c_sb_reg[C_STG];
    assign lc_t   = 26'(c_y_reg[C_STG]) * 26'd116 + 26'd128;

    always_comb
    begin
        grp_in.lcube     = 17'(lc_t >> 8) - 17'd4096;
        grp_in.lin       = cb_sb.lin;
        grp_in.bright    = cb_sb.bright;
        grp_in.bad_white = cb_sb.bad_white;
        grp_in.d_zero    = (cb_sb.d == 21'd0);
    end

    // linear lightness and chromaticity dividers, equal latency
    logic        lin_vld, u_vld, v_vld, un_vld, vn_vld;
    logic [29:0] lin_q, u_q, v_q, un_q, vn_q;
    grp_t        grp_out;

    xyzluv_div #(
        .NUM_W (40), .DEN_W (22), .Q_W (30), .SB_W ($bits(grp_t))
    ) u_div_lin (
        .clk (clk), .rst_n (rst_n), .in_valid (c_vld_reg[C_STG]),
        .num (cb_sb.lin_num), .den (cb_sb.lin_den), .sb_in (grp_in),
        .out_valid (lin_vld), .quo (lin_q), .sb_out (grp_out)
    );

    xyzluv_div #(
        .NUM_W (45), .DEN_W (21), .Q_W (30), .SB_W (1)
    ) u_div_u (
        .clk (clk), .rst_n (rst_n), .in_valid (c_vld_reg[C_STG]),
        .num ({cb_sb.x, 29'd0}), .den (cb_sb.d), .sb_in (1'b0),
        .out_valid (u_vld), .quo (u_q), .sb_out ()
    );

    xyzluv_div #(
        .NUM_W (47), .DEN_W (21), .Q_W (30), .SB_W (1)
    ) u_div_v (
        .clk (clk), .rst_n (rst_n), .in_valid (c_vld_reg[C_STG]),
        .num ({20'(cb_sb.y) * 20'd9, 27'd0}), .den (cb_sb.d), .sb_in (1'b0),
        .out_valid (v_vld), .quo (v_q), .sb_out ()
    );

    xyzluv_div #(
        .NUM_W (45), .DEN_W (21), .Q_W (30), .SB_W (1)
    ) u_div_un (
        .clk (clk), .rst_n (rst_n), .in_valid (c_vld_reg[C_STG]),
        .num ({cb_sb.wx, 29'd0}), .den (cb_sb.dn), .sb_in (1'b0),
        .out_valid (un_vld), .quo (un_q), .sb_out ()
    );

    xyzluv_div #(
        .NUM_W (47), .DEN_W (21), .Q_W (30), .SB_W (1)
    ) u_div_vn (
        .clk (clk), .rst_n (rst_n), .in_valid (c_vld_reg[C_STG]),
        .num ({20'(cb_sb.wy) * 20'd9, 27'd0}), .den (cb_sb.dn), .sb_in (1'b0),
        .out_valid (vn_vld), .quo (vn_q), .sb_out ()
    );

    // lightness select and chroma differences
    logic [16:0] l17;
    logic [29:0] up, vp;

    assign l17 = grp_out.lin    ? lin_q[16:0] :
                 grp_out.bright ? 17'h10000  : grp_out.lcube;
    assign up  = grp_out.d_zero ? 30'd0 : u_q;
    assign vp  = grp_out.d_zero ? 30'd0 : v_q;

    logic        m1_valid_reg;
    logic [15:0] m1_l_reg;
    logic        m1_sat_reg, m1_bad_reg;
    logic        m1_neg_u_reg, m1_neg_v_reg;
    logic [29:0] m1_mag_u_reg, m1_mag_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= lin_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_l_reg     <= l17[16] ? 16'hFFFF : l17[15:0];
        m1_sat_reg   <= l17[16];
        m1_bad_reg   <= grp_out.bad_white;
        m1_neg_u_reg <= (up < un_q);
        m1_mag_u_reg <= (up < un_q) ? un_q - up : up - un_q;
        m1_neg_v_reg <= (vp < vn_q);
        m1_mag_v_reg <= (vp < vn_q) ? vn_q - vp : vp - vn_q;
    end

    // 13 * L * |diff|
    logic        m2_valid_reg;
    logic [15:0] m2_l_reg;
    logic        m2_sat_reg, m2_bad_reg, m2_neg_u_reg, m2_neg_v_reg;
    logic [49:0] m2_prod_u_reg, m2_prod_v_reg;
    logic [19:0] l13;

    assign l13 = 20'(m1_l_reg) * 20'd13;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_l_reg      <= m1_l_reg;
        m2_sat_reg    <= m1_sat_reg;
        m2_bad_reg    <= m1_bad_reg;
        m2_neg_u_reg  <= m1_neg_u_reg;
        m2_neg_v_reg  <= m1_neg_v_reg;
        m2_prod_u_reg <= 50'(l13) * 50'(m1_mag_u_reg);
        m2_prod_v_reg <= 50'(l13) * 50'(m1_mag_v_reg);
    end

    // round half away from zero by 2^28, saturate; returns {sat, value}
    function automatic logic [16:0] chroma_sat(input logic [49:0] prod, input logic neg);
        logic [50:0] sum;
        logic [22:0] r;
        logic [15:0] val;
        logic        sat;
        sum = 51'(prod) + (51'd1 << 27);
        r   = 23'(sum >> 28);
        sat = 1'b0;
        if (neg)
        begin
            if (r > 23'd32768)
            begin
                sat = 1'b1;
                val = 16'h8000;
            end
            else
            begin
                val = 16'(23'd0 - r);
            end
        end
        else
        begin
            if (r > 23'd32767)
            begin
                sat = 1'b1;
                val = 16'h7FFF;
            end
            else
            begin
                val = r[15:0];
            end
        end
        return {sat, val};
    endfunction

    logic [16:0] cu, cv;
    logic        done_reg;
    luv_result_t result_reg;
    luv_result_t result_next;

    assign cu = chroma_sat(m2_prod_u_reg, m2_neg_u_reg);
    assign cv = chroma_sat(m2_prod_v_reg, m2_neg_v_reg);

    always_comb
    begin
        if (m2_bad_reg)
        begin
            result_next.lightness = '0;
            result_next.u_star    = '0;
            result_next.v_star    = '0;
            result_next.status    = STATUS_BAD_WHITE;
        end
        else
        begin
            result_next.lightness = m2_l_reg;
            result_next.u_star    = cu[15:0];
            result_next.v_star    = cv[15:0];
            result_next.status    = (m2_sat_reg || cu[16] || cv[16]) ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `XLUV_ASSERT_ALWAYS(a_div_aligned, (lin_vld == u_vld) && (lin_vld == v_vld)
        && (lin_vld == un_vld) && (lin_vld == vn_vld))
    `XLUV_ASSERT_IMPL(a_bad_white_zero, done && (result.status == STATUS_BAD_WHITE),
        (result.lightness == 16'd0) && (result.u_star == 16'sd0) && (result.v_star == 16'sd0))
    `XLUV_ASSERT_NEXT(a_transfer_enters, start && !busy, s1_valid_reg)

endmodule
